FILE: hw/rtl/falb_pkg.sv
// Shared types and constants for the flow-affinity load balancer.
`default_nettype none
package falb_pkg;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] ETH_BYTES     = 16'd14;
    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [3:0]  CFG_SERVER_COUNT   = 4'd0;
    localparam logic [3:0]  CFG_SERVER_WEIGHTS = 4'd1;
    // Flow key: addresses (64) plus ports and protocol (40).
    localparam int KEY_BITS = 104;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_SELECT,
        ST_WRITE
    } state_t;

    // Header length and protocol checks.
    function automatic logic header_ok(input logic [7:0] proto, input logic [3:0] ipw,
                                       input logic [3:0] tcpw, input logic [15:0] cap);
        logic [15:0] ip_bytes;
        logic [15:0] rest;
        logic        ok;
        ip_bytes = {10'd0, ipw, 2'b00};
        rest     = cap - ETH_BYTES;
        ok       = 1'b0;
        if (ip_bytes >= MIN_HDR_BYTES) begin
            if (proto == PROTO_UDP) begin
                ok = (cap >= ETH_BYTES) && (rest >= MIN_HDR_BYTES) && (rest >= ip_bytes)
                     && ((rest - ip_bytes) >= UDP_HDR_BYTES);
            end
            else if (proto == PROTO_TCP) begin
                ok = ({10'd0, tcpw, 2'b00} >= MIN_HDR_BYTES);
            end
        end
        return ok;
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/falb_server_pick.sv
// Registered weighted server choice: first server whose running weight sum reaches the pick.
`default_nettype none
module falb_server_pick #(
    parameter int MAX_SERVERS = 8
) (
    input  wire logic        clk,
    input  wire logic [3:0]  server_count,
    input  wire logic [63:0] server_weights,
    input  wire logic [6:0]  random_pick,
    output logic      [3:0]  server
);
    import falb_pkg::*;

    logic [3:0] server_next;

    always_comb
    begin
        logic [10:0] sum;
        logic [3:0]  n;
        logic        found;
        n           = (server_count > 4'(MAX_SERVERS)) ? 4'(MAX_SERVERS) : server_count;
        sum         = 11'd0;
        found       = 1'b0;
        server_next = 4'd0;
        for (int k = 0; k < MAX_SERVERS; k++) begin
            if (4'(k) < n && !found) begin
                sum = sum + {3'd0, server_weights[8*k +: 8]};
                if ({4'd0, random_pick} <= sum) begin
                    found       = 1'b1;
                    server_next = 4'(k + 1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        server <= server_next;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/flow_affinity_load_balancer_core.sv
// Top level of the flow-affinity load balancer.
`default_nettype none
// Command-style flow balancer. Pulse start while busy is low to transfer one parsed
// header; exactly one result is shown for one cycle with done high and cannot be held
// off. A rejected packet is answered without reading the table. An accepted packet
// walks the flow table through a single synchronous memory read port, entry by entry
// (issue the read, then compare). A hit ends the walk; a new flow goes on through the
// SELECT and WRITE states. busy drops as done rises, so the next command can be taken
// at the edge that ends the done cycle. Table memory needs no clearing: only entries
// below the fill count are read. Write configuration only while busy is low and no
// result is pending.
module flow_affinity_load_balancer_core #(
    parameter int FLOW_ENTRIES = 64,
    parameter int MAX_SERVERS  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  protocol,
    input  wire logic [3:0]  ip_header_words,
    input  wire logic [3:0]  tcp_offset_words,
    input  wire logic [15:0] capture_length,
    input  wire logic [31:0] source_address,
    input  wire logic [31:0] dest_address,
    input  wire logic [15:0] source_port,
    input  wire logic [15:0] dest_port,
    input  wire logic [6:0]  random_pick,
    output logic             done,
    output logic             accepted,
    output logic      [31:0] packet_number,
    output logic      [31:0] flow_number,
    output logic      [3:0]  server_number,
    output logic             new_flow,
    output logic             table_full
);
    import falb_pkg::*;

    localparam int AW = $clog2(FLOW_ENTRIES);
    localparam int CW = $clog2(FLOW_ENTRIES + 1);
    localparam int EW = KEY_BITS + 32 + 4;

    // Flow table: key, flow id and server in one word.
    logic [EW-1:0] table_mem [FLOW_ENTRIES];
    logic [EW-1:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [3:0]   server_count_reg;
    logic [63:0]  server_weights_reg;
    logic [31:0]  packet_counter_reg, packet_counter_next;
    logic [31:0]  flow_counter_reg, flow_counter_next;
    logic [CW-1:0] stored_reg, stored_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [6:0]   pick_reg;
    logic         ok_reg;
    logic [3:0]   picked;

    logic         done_next, acc_next, new_next, full_next;
    logic [31:0]  pkt_next, flow_next;
    logic [3:0]   srv_next;
    logic         wr_en;
    logic         rd_en;

    falb_server_pick #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_pick (
        .clk            (clk),
        .server_count   (server_count_reg),
        .server_weights (server_weights_reg),
        .random_pick    (pick_reg),
        .server         (picked)
    );

    assign busy = (state_reg != ST_IDLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            server_count_reg   <= 4'd1;
            server_weights_reg <= 64'd100;
        end
        else if (cfg_write) begin
            if (cfg_index == CFG_SERVER_COUNT) begin
                server_count_reg <= cfg_data[3:0];
            end
            else if (cfg_index == CFG_SERVER_WEIGHTS) begin
                server_weights_reg <= cfg_data;
            end
        end
    end

    // Capture the transferred item.
    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            key_reg  <= {source_address, dest_address, source_port, dest_port, protocol};
            pick_reg <= random_pick;
            ok_reg   <= header_ok(protocol, ip_header_words, tcp_offset_words,
                                  capture_length);
        end
    end

    // Table memory: one read port (registered), one write port.
    // A new entry stores the freshly issued flow id.
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= table_mem[idx_reg[AW-1:0]];
        end
        if (wr_en) begin
            table_mem[stored_reg[AW-1:0]] <= {key_reg, flow_counter_next, picked};
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        packet_counter_next = packet_counter_reg;
        flow_counter_next   = flow_counter_reg;
        stored_next         = stored_reg;
        idx_next            = idx_reg;
        done_next           = 1'b0;
        acc_next            = 1'b0;
        pkt_next            = 32'd0;
        flow_next           = 32'd0;
        srv_next            = 4'd0;
        new_next            = 1'b0;
        full_next           = 1'b0;
        wr_en               = 1'b0;
        rd_en               = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    state_next = ST_READ;
                    idx_next   = '0;
                end
            end
            ST_READ:
            begin
                if (!ok_reg) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else begin
                    if (idx_reg == '0) begin
                        packet_counter_next = packet_counter_reg + 32'd1;
                    end
                    if (idx_reg < stored_reg) begin
                        rd_en      = 1'b1;
                        state_next = ST_CMP;
                    end
                    else begin
                        state_next = ST_SELECT;
                    end
                end
            end
            ST_CMP:
            begin
                if (rd_data_reg[EW-1 -: KEY_BITS] == key_reg) begin
                    done_next  = 1'b1;
                    acc_next   = 1'b1;
                    pkt_next   = packet_counter_reg;
                    flow_next  = rd_data_reg[35:4];
                    srv_next   = rd_data_reg[3:0];
                    state_next = ST_IDLE;
                end
                else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_READ;
                end
            end
            ST_SELECT:
            begin
                // picked is registered; SELECT lets it settle before WRITE uses it.
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                flow_counter_next = flow_counter_reg + 32'd1;
                done_next  = 1'b1;
                acc_next   = 1'b1;
                pkt_next   = packet_counter_reg;
                flow_next  = flow_counter_reg + 32'd1;
                new_next   = 1'b1;
                state_next = ST_IDLE;
                if (picked != 4'd0) begin
                    if (stored_reg >= CW'(FLOW_ENTRIES)) begin
                        full_next = 1'b1;
                    end
                    else begin
                        srv_next    = picked;
                        wr_en       = 1'b1;
                        stored_next = stored_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg          <= ST_IDLE;
            packet_counter_reg <= 32'd0;
            flow_counter_reg   <= 32'd0;
            stored_reg         <= '0;
            idx_reg            <= '0;
            done               <= 1'b0;
        end
        else begin
            state_reg          <= state_next;
            packet_counter_reg <= packet_counter_next;
            flow_counter_reg   <= flow_counter_next;
            stored_reg         <= stored_next;
            idx_reg            <= idx_next;
            done               <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted      <= acc_next;
        packet_number <= pkt_next;
        flow_number   <= flow_next;
        server_number <= srv_next;
        new_flow      <= new_next;
        table_full    <= full_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= CW'(FLOW_ENTRIES)) else $error("fill count overflow");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_write_on_new: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_WRITE && picked != 4'd0)) else $error("stray write");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (stored_reg != $past(stored_reg)) |-> $past(wr_en)) else $error("fill changed");
`endif
endmodule
`default_nettype wire
